/* rtl/p2r_pkg.sv */
// Shared types, codes and helper functions for the pixel to RGBA8 converter.
package p2r_pkg;

    localparam int PixelW  = 64;
    localparam int KindW   = 3;
    localparam int WidthW  = 6;
    localparam int OrderW  = 3;
    localparam int IndexW  = 2;

    // Component kind codes.
    localparam logic [KindW-1:0] KIND_UNORM = 3'd0;
    localparam logic [KindW-1:0] KIND_UINT  = 3'd1;
    localparam logic [KindW-1:0] KIND_FLOAT = 3'd2;
    localparam logic [KindW-1:0] KIND_DEPTH = 3'd3;

    // Channel order codes.
    localparam logic [OrderW-1:0] ORDER_R    = 3'd0;
    localparam logic [OrderW-1:0] ORDER_RG   = 3'd1;
    localparam logic [OrderW-1:0] ORDER_RGB  = 3'd2;
    localparam logic [OrderW-1:0] ORDER_RGBA = 3'd3;
    localparam logic [OrderW-1:0] ORDER_BGRA = 3'd4;

    // Supported component widths.
    localparam logic [WidthW-1:0] WIDTH_8  = 6'd8;
    localparam logic [WidthW-1:0] WIDTH_16 = 6'd16;
    localparam logic [WidthW-1:0] WIDTH_32 = 6'd32;

    // Configuration register indexes.
    localparam logic [IndexW-1:0] REG_KIND  = 2'd0;
    localparam logic [IndexW-1:0] REG_WIDTH = 2'd1;
    localparam logic [IndexW-1:0] REG_ORDER = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [KindW-1:0]  KIND_RESET  = KIND_UNORM;
    localparam logic [WidthW-1:0] WIDTH_RESET = WIDTH_8;
    localparam logic [OrderW-1:0] ORDER_RESET = ORDER_RGBA;

    // How a lane decodes its component.
    typedef enum logic [2:0] {
        LANE_UNORM8  = 3'd0,
        LANE_UNORM16 = 3'd1,
        LANE_UINT32  = 3'd2,
        LANE_HALF    = 3'd3,
        LANE_SINGLE  = 3'd4
    } lane_mode_t;

    // Converted byte of one lane and its NaN flag.
    typedef struct packed {
        logic [7:0] value;
        logic       is_nan;
    } lane_result_t;

    // Widens a half float to single precision bits. Subnormal halves are far
    // below one step of 1/255, so they are flushed to a signed zero; the byte
    // they produce is zero either way.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [31:0] bits;
        e = h[14:10];
        if (e == 5'd0) begin
            bits = {h[15], 31'd0};
        end
        else if (e == 5'h1f) begin
            bits = {h[15], 8'hff, h[9:0], 13'd0};
        end
        else begin
            bits = {h[15], 3'd0, e + 5'd0, h[9:0], 13'd0} + {1'b0, 8'd112, 23'd0};
        end
        return bits;
    endfunction

endpackage

/* rtl/p2r_lane.sv */
// One channel lane: selects a component from the pixel and converts it to a byte.
module p2r_lane
    import p2r_pkg::*;
(
    input  logic [2*PixelW-1:0] pixel,
    input  logic [1:0]          slot,
    input  lane_mode_t          mode,
    output lane_result_t        result
);

    logic [7:0]  comp_byte;
    logic [15:0] comp_u16;
    logic [31:0] comp_u32;
    logic [31:0] fbits;
    logic [23:0] unorm_x;
    logic [7:0]  unorm_q;
    logic [16:0] unorm_r;
    logic [7:0]  float_byte;
    logic        float_nan;

    // Component extraction at the slot's byte offset.
    assign comp_byte = pixel[{slot, 3'd0} +: 8];
    assign comp_u16  = pixel[{slot, 4'd0} +: 16];
    assign comp_u32  = pixel[{slot, 5'd0} +: 32];

    // Unorm16 to byte: (v*255 + 32767) / 65535 by quotient estimate and one fix-up.
    always_comb
    begin
        unorm_x = {comp_u16, 8'd0} - {8'd0, comp_u16} + 24'd32767;
        unorm_q = unorm_x[23:16];
        unorm_r = {1'b0, unorm_x[15:0]} + {9'd0, unorm_q};
        if (unorm_r >= 17'd65535) begin
            unorm_q = unorm_q + 8'd1;
        end
    end

    assign fbits = (mode == LANE_HALF) ? half_to_single(comp_u16) : comp_u32;

    // Float to byte: clamp to 0..1, product by 255 rounded to single, then half up.
    always_comb
    begin
        logic [7:0]  e;
        logic [23:0] mant;
        logic [31:0] prod;
        logic [24:0] prod_rnd;
        logic        round_up;
        logic [7:0]  shift;
        logic [26:0] sum;
        logic [26:0] t;
        e          = fbits[30:23];
        mant       = {1'b1, fbits[22:0]};
        prod       = {mant, 8'd0} - {8'd0, mant};
        float_nan  = (e == 8'hff) && (fbits[22:0] != 23'd0);
        if (prod[31]) begin
            round_up = prod[7] && ((prod[6:0] != 7'd0) || prod[8]);
            prod_rnd = {1'b0, prod[31:8]} + {24'd0, round_up};
            shift    = 8'd142 - e;
        end
        else begin
            round_up = prod[6] && ((prod[5:0] != 6'd0) || prod[7]);
            prod_rnd = {1'b0, prod[30:7]} + {24'd0, round_up};
            shift    = 8'd143 - e;
        end
        sum = 27'd0;
        t   = 27'd0;
        if (shift <= 8'd26) begin
            sum = {2'd0, prod_rnd} + (27'd1 << (shift[4:0] - 5'd1));
            t   = sum >> shift[4:0];
        end
        if (float_nan || fbits[31] || (e == 8'd0)) begin
            float_byte = 8'd0;
        end
        else if (e >= 8'd127) begin
            float_byte = 8'd255;
        end
        else if (t > 27'd255) begin
            float_byte = 8'd255;
        end
        else begin
            float_byte = t[7:0];
        end
    end

    // Result selection by lane mode.
    always_comb
    begin
        result.is_nan = 1'b0;
        case (mode)
            LANE_UNORM8:  result.value = comp_byte;
            LANE_UNORM16: result.value = unorm_q;
            LANE_UINT32:  result.value = comp_u32[7:0];
            LANE_HALF,
            LANE_SINGLE:
            begin
                result.value  = float_byte;
                result.is_nan = float_nan;
            end
            default:      result.value = 8'd0;
        endcase
    end

endmodule

/* rtl/pixel_to_rgba8_converter.sv */
// Top level of the pixel to RGBA8 converter: configuration, input and result registers.
//
// The converter takes one source pixel per clock cycle and never stalls: busy
// stays low, so a transaction is accepted at every edge with start high. Each
// pixel passes through an input register and then a result register before
// its RGBA8 value is on the result ports, where it is flagged by result_valid
// for exactly one cycle. The receiver cannot hold results off and must take
// each one in that cycle. Configuration writes take effect at once and must
// only be made while no pixel is in flight.
module pixel_to_rgba8_converter
    import p2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PixelW-1:0] pixel_low,
    input  logic [PixelW-1:0] pixel_high,
    input  logic              wr_en,
    input  logic [IndexW-1:0] wr_index,
    input  logic [WidthW-1:0] wr_data,
    output logic              result_valid,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        alpha,
    output logic              conversion_ok
);

    logic [KindW-1:0]    kind_reg;
    logic [WidthW-1:0]   width_reg;
    logic [OrderW-1:0]   order_reg;
    logic                in_valid_reg;
    logic [2*PixelW-1:0] pixel_reg;
    logic                out_valid_reg;
    logic [7:0]          red_reg, green_reg, blue_reg, alpha_reg;
    logic                ok_reg;
    logic [7:0]          red_next, green_next, blue_next, alpha_next;
    logic                ok_next;
    logic [3:0]          present;
    logic [1:0]          slot [4];
    logic [1:0]          lane_slot [4];
    lane_mode_t          mode;
    lane_result_t        lane_res [4];

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg  <= KIND_RESET;
            width_reg <= WIDTH_RESET;
            order_reg <= ORDER_RESET;
        end
        else if (wr_en) begin
            case (wr_index)
                REG_KIND:  kind_reg  <= wr_data[KindW-1:0];
                REG_WIDTH: width_reg <= wr_data;
                REG_ORDER: order_reg <= wr_data[OrderW-1:0];
                default:   ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            pixel_reg <= {pixel_high, pixel_low};
        end
    end

    // Channel placement for the configured order.
    always_comb
    begin
        present = 4'b0000;
        slot[0] = 2'd0;
        slot[1] = 2'd1;
        slot[2] = 2'd2;
        slot[3] = 2'd3;
        case (order_reg)
            ORDER_R:    present = 4'b0001;
            ORDER_RG:   present = 4'b0011;
            ORDER_RGB:  present = 4'b0111;
            ORDER_RGBA: present = 4'b1111;
            ORDER_BGRA:
            begin
                present = 4'b1111;
                slot[0] = 2'd2;
                slot[2] = 2'd0;
            end
            default:    present = 4'b0000;
        endcase
    end

    // Lane decode mode from kind and width.
    always_comb
    begin
        mode = LANE_UNORM8;
        case (kind_reg)
            KIND_UNORM: mode = (width_reg == WIDTH_16) ? LANE_UNORM16 : LANE_UNORM8;
            KIND_UINT:  mode = LANE_UINT32;
            KIND_FLOAT: mode = (width_reg == WIDTH_16) ? LANE_HALF : LANE_SINGLE;
            KIND_DEPTH: mode = LANE_SINGLE;
            default:    mode = LANE_UNORM8;
        endcase
    end

    // Depth always reads the float at byte 0 through the red lane.
    assign lane_slot[0] = (kind_reg == KIND_DEPTH) ? 2'd0 : slot[0];
    assign lane_slot[1] = slot[1];
    assign lane_slot[2] = slot[2];
    assign lane_slot[3] = slot[3];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        p2r_lane u_lane (
            .pixel  (pixel_reg),
            .slot   (lane_slot[i]),
            .mode   (mode),
            .result (lane_res[i])
        );
    end

    // Pixel assembly, defaults, NaN handling and unsupported combinations.
    always_comb
    begin
        logic any_ch;
        logic w8, w16, w32;
        logic nan_color;
        any_ch     = (present != 4'b0000);
        w8         = (width_reg == WIDTH_8);
        w16        = (width_reg == WIDTH_16);
        w32        = (width_reg == WIDTH_32);
        nan_color  = (present[0] && lane_res[0].is_nan) ||
                     (present[1] && lane_res[1].is_nan) ||
                     (present[2] && lane_res[2].is_nan);
        red_next   = present[0] ? lane_res[0].value : 8'd0;
        green_next = present[1] ? lane_res[1].value : 8'd0;
        blue_next  = present[2] ? lane_res[2].value : 8'd0;
        alpha_next = present[3] ? lane_res[3].value : 8'd255;
        ok_next    = 1'b1;
        case (kind_reg)
            KIND_UNORM:
            begin
                if (any_ch && !(w8 || w16)) begin
                    ok_next = 1'b0;
                end
            end
            KIND_UINT:
            begin
                if (!w32) begin
                    ok_next = 1'b0;
                end
            end
            KIND_FLOAT:
            begin
                if (any_ch && !(w16 || w32)) begin
                    ok_next = 1'b0;
                end
                else if (nan_color) begin
                    red_next   = 8'd255;
                    green_next = 8'd0;
                    blue_next  = 8'd255;
                    alpha_next = 8'd255;
                end
                else if (present[3] && lane_res[3].is_nan) begin
                    alpha_next = 8'd255;
                end
            end
            KIND_DEPTH:
            begin
                alpha_next = 8'd255;
                if (!w32) begin
                    ok_next = 1'b0;
                end
                else if (lane_res[0].is_nan) begin
                    red_next   = 8'd255;
                    green_next = 8'd0;
                    blue_next  = 8'd255;
                end
                else begin
                    red_next   = lane_res[0].value;
                    green_next = lane_res[0].value;
                    blue_next  = lane_res[0].value;
                end
            end
            default:    ok_next = 1'b0;
        endcase
        if (!ok_next) begin
            red_next   = 8'd0;
            green_next = 8'd0;
            blue_next  = 8'd0;
            alpha_next = 8'd0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            ok_reg    <= ok_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign conversion_ok = ok_reg;

    // Every accepted transaction gives a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("accepted pixel produced no result");

    // No result appears without an earlier transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 2))
        else $error("result without accepted pixel");

    // A failed conversion delivers an all-zero pixel.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !conversion_ok) |->
        (red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
        else $error("failed conversion with nonzero pixel");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the pixel to RGBA8 converter.
module tb
    import p2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed.
    localparam logic [KindW-1:0]  KIND_SPARE    = 3'd7;
    localparam logic [OrderW-1:0] ORDER_ARGB    = 3'd5;
    localparam logic [OrderW-1:0] ORDER_UNKNOWN = 3'd6;
    localparam logic [OrderW-1:0] ORDER_SPARE   = 3'd7;
    localparam logic [IndexW-1:0] REG_SPARE     = 2'd3;
    localparam int  NO_OFFSET    = -1;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_ITEMS = 550;
    localparam int  PHASES       = 16;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       ok;
    } rgba_t;

    // Predicts converted pixels and checks results in order.
    class rgba_scoreboard;
        logic [KindW-1:0]  kind;
        logic [WidthW-1:0] width;
        logic [OrderW-1:0] order;
        rgba_t             pending[$];
        int                errors;
        int                checked;

        function new();
            kind = KIND_RESET;
            width = WIDTH_RESET;
            order = ORDER_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [IndexW-1:0] idx, logic [WidthW-1:0] data);
            if (idx == REG_KIND) kind = data[KindW-1:0];
            else if (idx == REG_WIDTH) width = data;
            else if (idx == REG_ORDER) order = data[OrderW-1:0];
        endfunction

        function logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int k);
            logic [63:0] w;
            w = (k < 8) ? lo : hi;
            return w[(k % 8) * 8 +: 8];
        endfunction

        function logic [15:0] u16_at(logic [63:0] lo, logic [63:0] hi, int k);
            return {byte_at(lo, hi, (k + 1) % 16), byte_at(lo, hi, k % 16)};
        endfunction

        function logic [31:0] u32_at(logic [63:0] lo, logic [63:0] hi, int k);
            return {u16_at(lo, hi, (k + 2) % 16), u16_at(lo, hi, k % 16)};
        endfunction

        // Half widening; subnormal halves give a zero byte either way.
        function logic [31:0] widen_half(logic [15:0] h);
            logic [7:0] e8;
            if (h[14:10] == 5'd0) return {h[15], 31'd0};
            if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
            e8 = {3'd0, h[14:10]} + 8'd112;
            return {h[15], e8, h[9:0], 13'd0};
        endfunction

        function bit is_nan(logic [31:0] f);
            return f[30:23] == 8'hff && f[22:0] != 23'd0;
        endfunction

        // Exact single-precision v*255 followed by round half away from zero.
        function logic [7:0] float_to_byte(logic [31:0] f);
            logic [63:0] prod, r, rem, half;
            int s, len, k, sh;
            logic [63:0] t;
            if (is_nan(f) || f[31] || f[30:0] == 31'd0) return 8'd0;
            if (f[30:0] >= 31'h3f800000) return 8'd255;
            if (f[30:23] == 8'd0) begin
                prod = {41'd0, f[22:0]} * 64'd255;
                s = -149;
            end
            else begin
                prod = {40'd0, 1'b1, f[22:0]} * 64'd255;
                s = int'(f[30:23]) - 150;
            end
            len = 0;
            for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
            k = (len > 24) ? len - 24 : 0;
            r = prod >> k;
            if (k > 0) begin
                rem = prod & ((64'd1 << k) - 1);
                half = 64'd1 << (k - 1);
                if (rem > half || (rem == half && r[0])) r = r + 1;
            end
            sh = -(s + k);
            if (sh > 60) return 8'd0;
            t = r >> sh;
            if (r[sh - 1]) t = t + 1;
            return (t > 255) ? 8'd255 : t[7:0];
        endfunction

        function int chan_offset(int ch, int nb);
            case (order)
                ORDER_R:    return (ch == 0) ? 0 : NO_OFFSET;
                ORDER_RG:   return (ch < 2) ? ch * nb : NO_OFFSET;
                ORDER_RGB:  return (ch < 3) ? ch * nb : NO_OFFSET;
                ORDER_RGBA: return ch * nb;
                ORDER_BGRA:
                begin
                    if (ch == 0) return 2 * nb;
                    if (ch == 1) return nb;
                    if (ch == 2) return 0;
                    return 3 * nb;
                end
                default:    return NO_OFFSET;
            endcase
        endfunction

        function rgba_t convert(logic [63:0] lo, logic [63:0] hi);
            rgba_t res, bad;
            logic [7:0]  px[4];
            logic [31:0] vals[4];
            logic [31:0] u;
            int nb, off;
            bit nan_color;
            bad = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
            nb = int'(width) / 8;
            px = '{8'd0, 8'd0, 8'd0, 8'd255};
            vals = '{32'd0, 32'd0, 32'd0, 32'h3f800000};
            nan_color = 0;
            case (kind)
                KIND_UNORM:
                begin
                    for (int ch = 0; ch < 4; ch++) begin
                        off = chan_offset(ch, nb);
                        if (off == NO_OFFSET) continue;
                        if (width == WIDTH_8) begin
                            px[ch] = byte_at(lo, hi, off % 16);
                        end
                        else if (width == WIDTH_16) begin
                            u = ({16'd0, u16_at(lo, hi, off)} * 32'd255 + 32'd32767) / 32'd65535;
                            px[ch] = u[7:0];
                        end
                        else begin
                            return bad;
                        end
                    end
                end
                KIND_UINT:
                begin
                    if (width != WIDTH_32) return bad;
                    for (int ch = 0; ch < 4; ch++) begin
                        off = chan_offset(ch, 4);
                        if (off != NO_OFFSET) px[ch] = byte_at(lo, hi, off % 16);
                    end
                end
                KIND_FLOAT:
                begin
                    for (int ch = 0; ch < 4; ch++) begin
                        off = chan_offset(ch, nb);
                        if (off == NO_OFFSET) continue;
                        if (width == WIDTH_16) vals[ch] = widen_half(u16_at(lo, hi, off));
                        else if (width == WIDTH_32) vals[ch] = u32_at(lo, hi, off);
                        else return bad;
                        if (ch < 3 && is_nan(vals[ch])) nan_color = 1;
                    end
                    if (nan_color) begin
                        px = '{8'd255, 8'd0, 8'd255, 8'd255};
                    end
                    else begin
                        for (int ch = 0; ch < 3; ch++) px[ch] = float_to_byte(vals[ch]);
                        px[3] = is_nan(vals[3]) ? 8'd255 : float_to_byte(vals[3]);
                    end
                end
                KIND_DEPTH:
                begin
                    if (width != WIDTH_32) return bad;
                    u = u32_at(lo, hi, 0);
                    if (is_nan(u)) begin
                        px = '{8'd255, 8'd0, 8'd255, 8'd255};
                    end
                    else begin
                        px[0] = float_to_byte(u);
                        px[1] = px[0];
                        px[2] = px[0];
                    end
                end
                default: return bad;
            endcase
            res = '{px[0], px[1], px[2], px[3], 1'b1};
            return res;
        endfunction

        function void note_input(logic [63:0] lo, logic [63:0] hi);
            pending.push_back(convert(lo, hi));
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
            errors++;
        endtask

        task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                          logic ok);
            rgba_t want;
            if (pending.size() == 0) begin
                $display("MISMATCH unexpected result transaction");
                errors++;
            end
            else begin
                want = pending.pop_front();
                if (r !== want.r) report("red", r, want.r);
                if (g !== want.g) report("green", g, want.g);
                if (b !== want.b) report("blue", b, want.b);
                if (a !== want.a) report("alpha", a, want.a);
                if (ok !== want.ok) report("conversion_ok", {7'd0, ok}, {7'd0, want.ok});
            end
            checked++;
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [PixelW-1:0] pixel_low;
    logic [PixelW-1:0] pixel_high;
    logic              wr_en;
    logic [IndexW-1:0] wr_index;
    logic [WidthW-1:0] wr_data;
    logic              result_valid;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              conversion_ok;

    rgba_scoreboard sb;
    int cycles;
    int sent;

    pixel_to_rgba8_converter uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_low(pixel_low), .pixel_high(pixel_high),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .red(red), .green(green), .blue(blue),
        .alpha(alpha), .conversion_ok(conversion_ok)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note accepted transactions, check results and watch the time limit.
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && start && !busy) sb.note_input(pixel_low, pixel_high);
        if (rst_n && result_valid)
            sb.check_result(red, green, blue, alpha, conversion_ok);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random 32-bit component biased toward the interesting float range.
    function logic [31:0] rand_single();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h3f800000);
            6:       return 32'h3f800000 - $urandom_range(0, 4096);
            7:       return {1'b1, 31'($urandom)};
            8:       return {1'($urandom), 8'hff, 23'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    function logic [15:0] rand_half();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 16'h3c00));
            6:       return 16'h3c00 - 16'($urandom_range(0, 64));
            7:       return {1'b1, 15'($urandom)};
            8:       return {1'($urandom), 5'h1f, 10'($urandom_range(0, 3))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Random pixel shaped by the current setting.
    task rand_pixel(output logic [63:0] lo, output logic [63:0] hi);
        if (sb.kind == KIND_FLOAT && sb.width == WIDTH_16) begin
            lo = {rand_half(), rand_half(), rand_half(), rand_half()};
            hi = {$urandom, $urandom};
        end
        else if ((sb.kind == KIND_FLOAT || sb.kind == KIND_DEPTH) && $urandom_range(0, 4) != 0)
        begin
            lo = {rand_single(), rand_single()};
            hi = {rand_single(), rand_single()};
        end
        else begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
    endtask

    // Directed pixel: zeros, ones, then float corner cases.
    task corner_pixel(int idx, output logic [63:0] lo, output logic [63:0] hi);
        logic [31:0] w[4];
        logic [15:0] h[4];
        case (idx)
            0:       begin w = '{4{32'h0}};               h = '{4{16'h0}}; end
            1:       begin w = '{4{32'hffffffff}};        h = '{4{16'hffff}}; end
            2:       begin w = '{4{32'h3f800000}};        h = '{4{16'h3c00}}; end
            3:       begin w = '{32'h7fc00000, 32'h3f000000, 32'h3f000000, 32'h3f000000};
                           h = '{16'h7e00, 16'h3800, 16'h3800, 16'h3800}; end
            4:       begin w = '{32'h3e800000, 32'h3e800000, 32'h3e800000, 32'h7fc00000};
                           h = '{16'h3400, 16'h3400, 16'h3400, 16'h7e00}; end
            5:       begin w = '{32'h3b008081, 32'h3b008080, 32'h3f7f7f7f, 32'h3f7fffff};
                           h = '{16'h1c04, 16'h1c00, 16'h3bf8, 16'h3bff}; end
            6:       begin w = '{32'hff800000, 32'h7f800000, 32'hbf800000, 32'h80000000};
                           h = '{16'hfc00, 16'h7c00, 16'hbc00, 16'h8000}; end
            7:       begin w = '{32'h00000001, 32'h007fffff, 32'h7f7fffff, 32'h3f000000};
                           h = '{16'h0001, 16'h03ff, 16'h7bff, 16'h3800}; end
            default: begin w = '{32'h3f400000, 32'h3e000000, 32'h3d800000, 32'h3f200000};
                           h = '{16'h3a00, 16'h3000, 16'h2c00, 16'h3900}; end
        endcase
        if (sb.width == WIDTH_16) begin
            lo = {h[3], h[2], h[1], h[0]};
            hi = {h[0], h[1], h[2], h[3]};
        end
        else begin
            lo = {w[1], w[0]};
            hi = {w[3], w[2]};
        end
    endtask

    // Drive one transaction and wait for it to be taken, then maybe idle.
    task send_pixel(logic [63:0] lo, logic [63:0] hi);
        int gap;
        start <= 1'b1;
        pixel_low <= lo;
        pixel_high <= hi;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let everything in flight drain, then write a new setting.
    task set_mode(logic [KindW-1:0] k, logic [WidthW-1:0] w, logic [OrderW-1:0] o,
                  bit spare);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_KIND;
        wr_data <= {3'd0, k};
        @(posedge clk);
        wr_index <= REG_WIDTH;
        wr_data <= w;
        @(posedge clk);
        wr_index <= REG_ORDER;
        wr_data <= {3'd0, o};
        @(posedge clk);
        if (spare) begin
            // A write to an unused index must change nothing.
            wr_index <= REG_SPARE;
            wr_data <= 6'($urandom);
            @(posedge clk);
        end
        wr_en <= 1'b0;
        sb.set_reg(REG_KIND, {3'd0, k});
        sb.set_reg(REG_WIDTH, w);
        sb.set_reg(REG_ORDER, {3'd0, o});
        @(posedge clk);
    endtask

    task run_corners(int count);
        logic [63:0] lo, hi;
        for (int i = 0; i < count; i++) begin
            corner_pixel(i, lo, hi);
            send_pixel(lo, hi);
        end
    endtask

    // Main sequence: reset, directed settings, then random settings.
    initial
    begin
        logic [63:0] lo, hi;
        logic [KindW-1:0]  k;
        logic [WidthW-1:0] w;
        logic [OrderW-1:0] o;
        sb = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel_low = '0;
        pixel_high = '0;
        wr_en = 1'b0;
        wr_index = REG_KIND;
        wr_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset setting, each kind, and the register extremes.
        run_corners(2);
        set_mode(KIND_FLOAT, WIDTH_32, ORDER_RGBA, 1'b1);
        run_corners(9);
        set_mode(KIND_FLOAT, WIDTH_16, ORDER_BGRA, 1'b0);
        run_corners(9);
        set_mode(KIND_DEPTH, WIDTH_32, ORDER_R, 1'b0);
        run_corners(3);
        set_mode(KIND_UNORM, WIDTH_16, ORDER_BGRA, 1'b0);
        run_corners(2);
        set_mode(KIND_UINT, WIDTH_32, ORDER_RGB, 1'b0);
        run_corners(2);
        set_mode(KIND_SPARE, 6'd63, ORDER_SPARE, 1'b1);
        run_corners(1);
        set_mode(KIND_UNORM, 6'd0, ORDER_ARGB, 1'b0);
        run_corners(1);
        set_mode(KIND_UINT, WIDTH_16, ORDER_UNKNOWN, 1'b0);
        run_corners(1);

        // Random part: mostly supported settings with random pixels.
        for (int p = 0; p < PHASES; p++) begin
            if ($urandom_range(0, 5) == 0) begin
                k = 3'($urandom);
                w = 6'($urandom);
                o = 3'($urandom);
            end
            else begin
                k = 3'($urandom_range(KIND_UNORM, KIND_DEPTH));
                case ($urandom_range(0, 2))
                    0:       w = WIDTH_8;
                    1:       w = WIDTH_16;
                    default: w = WIDTH_32;
                endcase
                o = 3'($urandom_range(ORDER_R, ORDER_BGRA));
                if ($urandom_range(0, 7) == 0) o = ORDER_ARGB;
            end
            set_mode(k, w, o, $urandom_range(0, 3) == 0);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                rand_pixel(lo, hi);
                send_pixel(lo, hi);
            end
        end

        // Drain and finish.
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        $display("Converted %0d pixels over %0d random settings and the directed corners.",
                 sent, PHASES);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb passed");
        end
        else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/p2r_pkg.sv
rtl/p2r_lane.sv
rtl/pixel_to_rgba8_converter.sv
verif/tb.sv
